// ----- rtl/assert_macros.svh -----
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FLA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define FLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FLA_ASSERT(lbl, clk, rstn, prop, msg)

`define FLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/fla_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fla_pkg;

  localparam int unsigned IdW     = 10;
  localparam int unsigned StatusW = 2;

  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StNotGiven = 2'd2;

  typedef logic [IdW-1:0]     id_t;
  typedef logic [StatusW-1:0] status_t;

endpackage

`default_nettype wire

// ----- rtl/fla_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fla_req_if;
  logic           valid;
  logic           ready;
  logic           opcode;
  fla_pkg::id_t   release_id;

  modport source (output valid, output opcode, output release_id, input ready);
  modport sink   (input valid, input opcode, input release_id, output ready);
endinterface

interface fla_rsp_if;
  logic             valid;
  logic             ready;
  fla_pkg::id_t     granted_id;
  fla_pkg::status_t status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/fla_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fla_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output      logic [Width-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/free_list_id_allocator_core.sv -----
`timescale 1ns / 1ps
// channel   port    dir  word
// request   req_i   in   opcode, release_id
// response  rsp_o   out  granted_id, status
//
// In S_IDLE an accepted word reads the link and given-flag memories at the head
// or at the released id; in S_EXEC it updates and writes back, as the memory
// read is registered. Reset is immediate: ids at or above the fresh mark count
// as never used, so the memories need no clearing pass. A stalled response holds
// the update back; a new request is taken once the update is done.
`default_nettype none
`include "assert_macros.svh"

module free_list_id_allocator_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fla_req_if.sink    req_i,
  fla_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned HW   = IdxW + 1;
  localparam int unsigned CW   = (HW > fla_pkg::IdW) ? HW : fla_pkg::IdW;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e             state_q, state_d;
  logic [HW-1:0]      head_q, head_d;
  logic [HW-1:0]      fresh_q, fresh_d;
  logic               op_q, op_d;
  logic [CW-1:0]      id_q, id_d;
  logic               rsp_valid_q, rsp_valid_d;
  fla_pkg::id_t       granted_q, granted_d;
  fla_pkg::status_t   status_q, status_d;

  logic               accept;
  logic               fire;
  logic [IdxW-1:0]    rd_addr;
  logic [HW-1:0]      link_rd;
  logic               given_rd;
  logic               link_wr_en;
  logic               given_wr_en;
  logic               given_wr_data;
  logic [IdxW-1:0]    wr_addr;
  logic [HW-1:0]      link;
  logic               full;
  logic               rel_ok;
  logic [CW-1:0]      req_id_ext;

  assign req_id_ext = CW'(req_i.release_id);
  assign accept     = req_i.valid && req_i.ready;
  assign fire       = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign rd_addr    = (req_i.opcode == fla_pkg::OpAlloc) ? head_q[IdxW-1:0]
                                                         : req_id_ext[IdxW-1:0];

  assign full   = head_q >= HW'(CAPACITY);
  assign link   = (head_q < fresh_q) ? link_rd : '0;
  assign rel_ok = (id_q != '0) && (id_q < CW'(CAPACITY)) && (id_q < CW'(fresh_q))
                  && given_rd;

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    fresh_d       = fresh_q;
    op_d          = op_q;
    id_d          = id_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    granted_d     = granted_q;
    status_d      = status_q;
    link_wr_en    = 1'b0;
    given_wr_en   = 1'b0;
    given_wr_data = 1'b0;
    wr_addr       = head_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = req_i.opcode;
          id_d    = req_id_ext;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          rsp_valid_d = 1'b1;
          granted_d   = '0;
          status_d    = fla_pkg::StOk;
          state_d     = S_IDLE;
          if (op_q == fla_pkg::OpAlloc) begin
            if (full) begin
              status_d = fla_pkg::StFull;
            end else begin
              granted_d     = fla_pkg::IdW'(head_q);
              given_wr_en   = 1'b1;
              given_wr_data = 1'b1;
              head_d        = (link == '0) ? HW'(head_q + 1'b1) : link;
              if (head_q >= fresh_q) begin
                fresh_d = HW'(head_q + 1'b1);
              end
            end
          end else begin
            wr_addr = id_q[IdxW-1:0];
            if (rel_ok) begin
              given_wr_en = 1'b1;
              link_wr_en  = 1'b1;
              head_d      = HW'(id_q);
            end else begin
              status_d = fla_pkg::StNotGiven;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= HW'(1);
      fresh_q     <= HW'(1);
      op_q        <= fla_pkg::OpAlloc;
      id_q        <= '0;
      rsp_valid_q <= 1'b0;
      granted_q   <= '0;
      status_q    <= fla_pkg::StOk;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fresh_q     <= fresh_d;
      op_q        <= op_d;
      id_q        <= id_d;
      rsp_valid_q <= rsp_valid_d;
      granted_q   <= granted_d;
      status_q    <= status_d;
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.granted_id = granted_q;
  assign rsp_o.status     = status_q;

  fla_mem #(
    .Depth (CAPACITY),
    .Width (HW)
  ) u_link_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (link_rd),
    .wr_en_i   (link_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (head_q)
  );

  fla_mem #(
    .Depth (CAPACITY),
    .Width (1)
  ) u_given_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (given_rd),
    .wr_en_i   (given_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (given_wr_data)
  );

  `FLA_ASSERT(a_head_range, clk_i, rst_ni, (head_q != '0) && (head_q <= HW'(CAPACITY)), "free head out of range")
  `FLA_ASSERT(a_head_fresh, clk_i, rst_ni, head_q <= fresh_q, "free head beyond fresh mark")
  `FLA_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, accept, (state_q == S_EXEC) && !req_i.ready, "request taken during update")
  `FLA_ASSERT(a_grant_ok, clk_i, rst_ni, !rsp_valid_q || (status_q == fla_pkg::StOk) || (granted_q == '0), "id granted with error status")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Capacity = 1024;

  typedef logic [fla_pkg::IdW:0] head_t;

  typedef struct packed {
    fla_pkg::id_t     granted_id;
    fla_pkg::status_t status;
  } grant_word_t;

  // Shadow of the id pool plus the queue of grant words still owed by the block.
  class id_pool_scoreboard;
    head_t        next_link [Capacity];
    bit           is_given  [Capacity];
    head_t        head;
    fla_pkg::id_t held_ids [$];
    fla_pkg::id_t last_freed;
    grant_word_t  pending_grants [$];
    int unsigned  n_mismatches;

    function new();
      foreach (next_link[i]) begin
        next_link[i] = '0;
        is_given[i]  = 1'b0;
      end
      head         = head_t'(1);
      last_freed   = '0;
      n_mismatches = 0;
    endfunction

    task report(string what);
      n_mismatches++;
      if (n_mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function bit exhausted();
      return head >= Capacity;
    endfunction

    function void note_request(logic op, fla_pkg::id_t id);
      grant_word_t  w;
      fla_pkg::id_t pick;
      int           k;
      w.granted_id = '0;
      w.status     = fla_pkg::StOk;
      if (op == fla_pkg::OpAlloc) begin
        if (head == '0 || head >= Capacity) begin
          w.status = fla_pkg::StFull;
        end else begin
          pick = head[fla_pkg::IdW-1:0];
          // a zero link means never used: step on to the next fresh id
          head = (next_link[pick] == '0) ? head + 1'b1 : next_link[pick];
          is_given[pick] = 1'b1;
          held_ids.push_back(pick);
          w.granted_id = pick;
        end
      end else if (id != '0 && id < Capacity && is_given[id]) begin
        is_given[id]  = 1'b0;
        next_link[id] = head;
        head          = {1'b0, id};
        last_freed    = id;
        for (k = 0; k < held_ids.size(); k++) begin
          if (held_ids[k] == id) break;
        end
        held_ids.delete(k);
      end else begin
        w.status = fla_pkg::StNotGiven;
      end
      pending_grants.push_back(w);
    endfunction

    task check_response(fla_pkg::id_t granted_id, fla_pkg::status_t status);
      grant_word_t w;
      if (pending_grants.size() == 0) begin
        report($sformatf("response word id=%0d status=%0d with nothing pending",
                         granted_id, status));
        return;
      end
      w = pending_grants.pop_front();
      if (granted_id !== w.granted_id)
        report($sformatf("granted_id %0d, expected %0d", granted_id, w.granted_id));
      if (status !== w.status)
        report($sformatf("status %0d, expected %0d", status, w.status));
    endtask

    task close_out();
      if (pending_grants.size() != 0)
        report($sformatf("%0d response words never arrived", pending_grants.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;

  id_pool_scoreboard sb;

  fla_req_if req_if ();
  fla_rsp_if rsp_if ();

  free_list_id_allocator_core #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    sb     = new();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(logic op, fla_pkg::id_t id);
    int unsigned gap;
    gap = idle_on ? $urandom_range(10) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.release_id <= id;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, id);
  endtask

  task automatic random_word(int unsigned alloc_pct, int unsigned held_pct);
    int unsigned sel;
    if ($urandom_range(99) < alloc_pct) begin
      send_word(fla_pkg::OpAlloc, fla_pkg::id_t'($urandom));
    end else if (sb.held_ids.size() != 0 && $urandom_range(99) < held_pct) begin
      send_word(fla_pkg::OpRelease,
                sb.held_ids[$urandom_range(sb.held_ids.size() - 1)]);
    end else begin
      sel = $urandom_range(3);
      case (sel)
        0: begin
          send_word(fla_pkg::OpRelease, sb.last_freed);
        end
        1: begin
          send_word(fla_pkg::OpRelease, '0);
        end
        default: begin
          send_word(fla_pkg::OpRelease, fla_pkg::id_t'($urandom));
        end
      endcase
    end
  endtask

  // hold the request side off until the response queue is empty
  task automatic drain_pool_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_grants.size() != 0);
  endtask

  initial begin : rsp_sink
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(10) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_response(rsp_if.granted_id, rsp_if.status);
    end
  end

  initial begin : stimulus
    req_if.valid      <= 1'b0;
    req_if.opcode     <= fla_pkg::OpAlloc;
    req_if.release_id <= '0;
    idle_on = 1'b1;
    @(posedge clk_i iff rst_ni);

    // releases before anything is given, null id included
    send_word(fla_pkg::OpRelease, '0);
    send_word(fla_pkg::OpRelease, '1);
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(512));
    // fresh ids in order; release_id is don't-care here
    send_word(fla_pkg::OpAlloc, '1);
    send_word(fla_pkg::OpAlloc, '0);
    send_word(fla_pkg::OpAlloc, fla_pkg::id_t'(341));
    // double release, then LIFO reuse
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(2));
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(2));
    send_word(fla_pkg::OpAlloc, fla_pkg::id_t'(682));
    send_word(fla_pkg::OpAlloc, '0);
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(1));
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(3));
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(4));
    repeat (4) send_word(fla_pkg::OpAlloc, '0);
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(6));
    send_word(fla_pkg::OpRelease, fla_pkg::id_t'(1023));

    repeat (80) random_word(55, 70);
    idle_on = 1'b0;
    repeat (40) random_word(55, 70);
    drain_pool_responses();

    // fill the pool, then work around the exhausted state
    idle_on = 1'b1;
    while (!sb.exhausted()) random_word(98, 80);
    repeat (20) random_word(50, 90);
    drain_pool_responses();

    repeat (40) random_word(25, 90);
    repeat (3) begin
      idle_on = 1'($urandom_range(1));
      repeat (20) random_word(50, 75);
    end

    req_if.valid <= 1'b0;
    idle_on = 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.close_out();
    if (sb.n_mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fla_pkg.sv
rtl/fla_if.sv
rtl/fla_mem.sv
rtl/free_list_id_allocator_core.sv
tb/sv/tb.sv
